// ===== rtl/incremental_pid_clamped_defines.svh =====
// Assertion helpers for the incremental PID block.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef INCREMENTAL_PID_CLAMPED_DEFINES_SVH
`define INCREMENTAL_PID_CLAMPED_DEFINES_SVH

// Check cons in the same cycle as ante.
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ipc_pkg.sv =====
`default_nettype none

package ipc_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned DELTA_W = 19;
  localparam int unsigned PROD_W  = DATA_W + DELTA_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned Q_FRAC  = 8;
  localparam int unsigned QUO_W   = ACC_W - Q_FRAC;
  localparam int unsigned QMAG_W  = QUO_W - 1;

  // floor(m / 10) == (m * RECIP10) >> RECIP10_SHIFT for every m below 2**QMAG_W
  localparam int unsigned RECIP10_SHIFT = 30;
  localparam int unsigned RECIP10_W     = 27;
  localparam logic [RECIP10_W-1:0] RECIP10 = 27'd107374183;
  localparam int unsigned DIV10_W = QMAG_W + RECIP10_W - RECIP10_SHIFT;

  localparam int unsigned SUM_W = DIV10_W + 2;

  localparam logic signed [DATA_W-1:0] GAIN_P_RST  = 16'sd4608;
  localparam logic signed [DATA_W-1:0] GAIN_I_RST  = 16'sd1024;
  localparam logic signed [DATA_W-1:0] GAIN_D_RST  = 16'sd256;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 16'sh8000;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MAX = 3'd3,
    REG_OUT_MIN = 3'd4
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== rtl/incremental_pid_clamped.sv =====
// Incremental (velocity-form) PID controller with a clamped held drive value.
//
// Channels: in_* carries one control sample (setpoint, measured), out_* one
// result (drive magnitude and signed drive value), both with valid/ready; a
// transfer happens on a clock edge with valid and ready high. cfg_* writes
// one gain or clamp limit by register index; it is always ready, and an
// unknown index is dropped. Write configuration only while the block is idle.
//
// Throughput: one sample per cycle while the output is not stalled. A
// sample passes the input register, three arithmetic stages and the result
// register. The multiplies and the divide by ten set the depth; the held
// drive value closes its loop in the last stage alone.
//
// Stall: when a result waits and out_ready_i is low, the whole pipeline
// holds and in_ready_o drops; everything advances again the cycle the
// result is taken.
//
// Reset: gains and limits return to their defaults, the error history and
// the held drive value clear to zero, and the pipeline empties.
`default_nettype none

module incremental_pid_clamped
  import ipc_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [DATA_W-1:0]           cfg_data_i,

  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic signed [DATA_W-1:0]    setpoint_i,
  input  wire logic signed [DATA_W-1:0]    measured_i,

  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [DATA_W-1:0]           drive_magnitude_o,
  output      logic signed [DATA_W-1:0]    drive_value_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [DATA_W-1:0] out_max_q, out_min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= GAIN_P_RST;
      gain_i_q  <= GAIN_I_RST;
      gain_d_q  <= GAIN_D_RST;
      out_max_q <= OUT_MAX_RST;
      out_min_q <= OUT_MIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P:  gain_p_q  <= cfg_data_i;
        REG_GAIN_I:  gain_i_q  <= cfg_data_i;
        REG_GAIN_D:  gain_d_q  <= cfg_data_i;
        REG_OUT_MAX: out_max_q <= cfg_data_i;
        REG_OUT_MIN: out_min_q <= cfg_data_i;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline advance: every stage moves together whenever the result
  // register is empty or is being taken this cycle.
  // ---------------------------------------------------------------------
  logic advance;
  logic s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic signed [DATA_W-1:0] setpoint_q, measured_q;

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      setpoint_q <= setpoint_i;
      measured_q <= measured_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: error, first and second difference, three gain products.
  // The error history updates here, one sample per cycle while the pipeline advances.
  // ---------------------------------------------------------------------
  logic [DATA_W:0]           meas_abs;
  logic signed [ERR_W-1:0]   err;
  logic signed [DELTA_W-1:0] delta1, delta2;
  logic signed [ERR_W-1:0]   last_error_q;
  logic signed [DELTA_W-1:0] last_delta_q;
  logic signed [PROD_W-1:0]  prod_p_q, prod_i_q, prod_d_q;

  always_comb begin
    meas_abs = measured_q[DATA_W-1] ? (DATA_W+1)'(-$signed({measured_q[DATA_W-1], measured_q}))
                                    : {1'b0, measured_q};
    err      = ERR_W'(setpoint_q) - $signed(ERR_W'(meas_abs));
    delta1   = DELTA_W'(err) - DELTA_W'(last_error_q);
    delta2   = delta1 - last_delta_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q <= '0;
      last_delta_q <= '0;
    end else if (advance && s0_valid_q) begin
      last_error_q <= err;
      last_delta_q <= delta1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s0_valid_q) begin
      prod_p_q <= PROD_W'(gain_p_q * delta1);
      prod_i_q <= PROD_W'(gain_i_q * err);
      prod_d_q <= PROD_W'(gain_d_q * delta2);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: sum the products and drop the Q8.8 fraction toward zero
  // ---------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc, acc_biased;
  logic signed [QUO_W-1:0] q_int_q;

  always_comb begin
    acc        = ACC_W'(prod_p_q) + ACC_W'(prod_i_q) + ACC_W'(prod_d_q);
    acc_biased = acc + (acc[ACC_W-1] ? ACC_W'((1 << Q_FRAC) - 1) : ACC_W'(0));
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      q_int_q <= QUO_W'(acc_biased >>> Q_FRAC);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: divide by ten on the magnitude with a reciprocal multiply
  // ---------------------------------------------------------------------
  logic [QMAG_W-1:0]           q_mag;
  logic [QMAG_W+RECIP10_W-1:0] recip_prod;
  logic [DIV10_W-1:0]          div10_q;
  logic                        div10_neg_q;

  always_comb begin
    q_mag      = q_int_q[QUO_W-1] ? QMAG_W'(-q_int_q) : QMAG_W'(q_int_q);
    recip_prod = (QMAG_W+RECIP10_W)'(q_mag) * (QMAG_W+RECIP10_W)'(RECIP10);
  end

  always_ff @(posedge clk_i) begin
    if (advance && s2_valid_q) begin
      div10_q     <= recip_prod[QMAG_W+RECIP10_W-1:RECIP10_SHIFT];
      div10_neg_q <= q_int_q[QUO_W-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: accumulate into the held value and clamp. The upper limit
  // is checked first, so it wins when the limits cross.
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0]  incr, sum;
  logic signed [DATA_W-1:0] held_d, held_q;
  logic [DATA_W-1:0]        mag_d, mag_q;

  always_comb begin
    incr = div10_neg_q ? -$signed({2'b00, div10_q}) : $signed({2'b00, div10_q});
    sum  = SUM_W'(held_q) + incr;
    if (sum >= SUM_W'(out_max_q)) begin
      held_d = out_max_q;
    end else if (sum <= SUM_W'(out_min_q)) begin
      held_d = out_min_q;
    end else begin
      held_d = DATA_W'(sum);
    end
    mag_d = held_d[DATA_W-1] ? DATA_W'(-held_d) : DATA_W'(held_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (advance && s3_valid_q) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s3_valid_q) begin
      mag_q <= mag_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign drive_value_o     = held_q;
  assign drive_magnitude_o = mag_q;

endmodule

`default_nettype wire

// ===== rtl/ipc_checker.sv =====
`default_nettype none
`include "incremental_pid_clamped_defines.svh"

module ipc_checker
  import ipc_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [DATA_W-1:0]        drive_magnitude_o,
  input wire logic signed [DATA_W-1:0] drive_value_o
);

  logic              out_stall;
  logic [DATA_W-1:0] value_abs;

  assign out_stall = out_valid_o && !out_ready_i;
  assign value_abs = drive_value_o[DATA_W-1] ? DATA_W'(-drive_value_o) : drive_value_o;

  // A stalled result holds.
  `IPC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(drive_value_o), "stall moved result")

  // A stalled result blocks new samples.
  `IPC_ASSERT_NOW(a_stall_blocks_in, out_stall, !in_ready_o, "input taken during output stall")

  // Magnitude agrees with the signed value.
  `IPC_ASSERT_NOW(a_mag_match, out_valid_o, drive_magnitude_o == value_abs, "magnitude mismatch")

  // The held value moves only together with a new result.
  `IPC_ASSERT_NOW(a_value_with_valid, !$stable(drive_value_o), out_valid_o, "value moved alone")

endmodule

bind incremental_pid_clamped ipc_checker u_ipc_checker (.*);

`default_nettype wire
